FILE: rtl/bdq_pkg.sv
// Shared widths, operation and status codes, and cell command type for the deque.
package bdq_pkg;

  localparam int OP_W   = 3;
  localparam int WORD_W = 32;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int ST_W   = 2;

  localparam int CAPACITY_DEF = 64;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_SWAP       = 3'd4;
  localparam logic [OP_W-1:0] OP_SORT       = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // Actions broadcast to every cell of the row
  localparam logic [2:0] ACT_HOLD     = 3'd0;
  localparam logic [2:0] ACT_LOAD_AT  = 3'd1;
  localparam logic [2:0] ACT_SHIFT_UP = 3'd2;
  localparam logic [2:0] ACT_SHIFT_DN = 3'd3;
  localparam logic [2:0] ACT_SWAP     = 3'd4;
  localparam logic [2:0] ACT_SORT     = 3'd5;

  typedef struct packed {
    logic [2:0] act;
    logic       parity;  // odd-even exchange phase
  } cell_cmd_t;

endpackage

FILE: rtl/bdq_if.sv
// Valid/ready channel interfaces for request and result items.
interface bdq_in_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [WORD_W-1:0] value;
  logic [IDX_W-1:0]         index_a;
  logic [IDX_W-1:0]         index_b;

  modport source (output valid, operation, value, index_a, index_b, input ready);
  modport sink (input valid, operation, value, index_a, index_b, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] popped;
  logic [CNT_W-1:0]         count;
  logic [ST_W-1:0]          status;

  modport source (output valid, popped, count, status, input ready);
  modport sink (input valid, popped, count, status, output ready);
endinterface

FILE: rtl/bounded_deque_with_sort.sv
// Bounded deque of signed words held in a row of shifting cells, with in-place sort.
// Push back, push front, pop front and every rejected or unused request load their
// result in the accept cycle, so such items can be accepted back to back while the
// receiver keeps up; the result sits in an output register and a new item is taken
// while it drains. Pop back and an in-range swap pass through S_RD1 and S_RD2 while
// the two-stage registered select tree reads an arbitrary cell. Sort runs one odd-even
// exchange phase per cycle across the row, CAPACITY phases in all. Count is fill's low 7 bits.
module bounded_deque_with_sort import bdq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bdq_in_if.sink    in_ch,
  bdq_out_if.source out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;
  localparam logic [1:0] S_SORT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     phase_r, phase_nxt;
  logic [OP_W-1:0]   op_r;
  logic [AW-1:0]     ia_r, ib_r;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_popped_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [ST_W-1:0]   out_status_r;

  logic              in_ready, accept;
  logic              full, empty, range_err;
  logic              res_load;
  logic [WORD_W-1:0] res_popped;
  logic [ST_W-1:0]   res_status;

  cell_cmd_t         cmd;
  logic [AW-1:0]     sel_a;
  logic [AW-1:0]     rd_addr_a, rd_addr_b;
  logic [WORD_W-1:0] rd_a, rd_b;
  logic [WORD_W-1:0] words [CAPACITY];

  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  assign full      = (fill_r == CW'(CAPACITY));
  assign empty     = (fill_r == '0);
  assign range_err = (XW'(in_ch.index_a) >= XW'(fill_r)) ||
                     (XW'(in_ch.index_b) >= XW'(fill_r));

  // Read addresses are presented in the accept cycle; data lands after both select-tree registers
  assign rd_addr_a = (in_ch.operation == OP_POP_BACK) ? AW'(fill_r - CW'(1))
                                                      : AW'(in_ch.index_a);
  assign rd_addr_b = AW'(in_ch.index_b);
  assign sel_a     = (state_r == S_IDLE) ? AW'(fill_r) : ia_r;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    phase_nxt  = phase_r;
    cmd.act    = ACT_HOLD;
    cmd.parity = phase_r[0];
    res_load   = 1'b0;
    res_popped = '0;
    res_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (in_ch.operation)
            OP_PUSH_BACK: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                cmd.act  = ACT_LOAD_AT;
                fill_nxt = fill_r + CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                res_load  = 1'b0;
                state_nxt = S_RD1;
              end
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                cmd.act  = ACT_SHIFT_UP;
                fill_nxt = fill_r + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                res_popped = words[0];
                cmd.act    = ACT_SHIFT_DN;
                fill_nxt   = fill_r - CW'(1);
              end
            end
            OP_SWAP: begin
              if (range_err) begin
                res_status = ST_RANGE;
              end else begin
                res_load  = 1'b0;
                state_nxt = S_RD1;
              end
            end
            OP_SORT: begin
              res_load  = 1'b0;
              phase_nxt = '0;
              state_nxt = S_SORT;
            end
            default: ;  // unused codes leave the store alone
          endcase
        end
      end
      S_RD1: begin
        state_nxt = S_RD2;
      end
      S_RD2: begin
        res_load  = 1'b1;
        state_nxt = S_IDLE;
        if (op_r == OP_POP_BACK) begin
          res_popped = rd_a;
          fill_nxt   = fill_r - CW'(1);
        end else begin
          cmd.act = ACT_SWAP;
        end
      end
      S_SORT: begin
        cmd.act   = ACT_SORT;
        phase_nxt = phase_r + AW'(1);
        if (phase_r == AW'(CAPACITY - 1)) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = res_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_ch.operation;
      ia_r <= AW'(in_ch.index_a);
      ib_r <= AW'(in_ch.index_b);
    end
    if (res_load) begin
      out_popped_r <= res_popped;
      out_count_r  <= CNT_W'(fill_nxt);
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.popped = out_popped_r;
  assign out_ch.count  = out_count_r;
  assign out_ch.status = out_status_r;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (g == 0) begin : g_lo
      assign left_w = '0;
    end else begin : g_lo
      assign left_w = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign right_w = '0;
    end else begin : g_hi
      assign right_w = words[g+1];
    end
    bdq_cell #(.CAPACITY(CAPACITY), .IDX(g)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .val   (in_ch.value),
      .sel_a (sel_a),
      .sel_b (ib_r),
      .dat_a (rd_a),
      .dat_b (rd_b),
      .fill  (fill_r),
      .left  (left_w),
      .right (right_w),
      .word  (words[g])
    );
  end

  bdq_rdsel #(.CAPACITY(CAPACITY)) u_rd_a (
    .clk   (clk),
    .words (words),
    .addr  (rd_addr_a),
    .data  (rd_a)
  );

  bdq_rdsel #(.CAPACITY(CAPACITY)) u_rd_b (
    .clk   (clk),
    .words (words),
    .addr  (rd_addr_b),
    .data  (rd_b)
  );

endmodule

FILE: rtl/bdq_cell.sv
// One storage cell of the deque row: load, shift, swap and odd-even exchange.
module bdq_cell import bdq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX      = 0,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [WORD_W-1:0] val,
  input  logic [AW-1:0]     sel_a,
  input  logic [AW-1:0]     sel_b,
  input  logic [WORD_W-1:0] dat_a,
  input  logic [WORD_W-1:0] dat_b,
  input  logic [CW-1:0]     fill,
  input  logic [WORD_W-1:0] left,
  input  logic [WORD_W-1:0] right,
  output logic [WORD_W-1:0] word
);

  localparam logic PAR = IDX[0];

  logic [WORD_W-1:0] word_r, word_nxt;
  logic              pair_right, pair_left;

  // Paired with the right neighbor: keep the smaller; with the left: keep the larger
  assign pair_right = (cmd.parity == PAR) && (CW'(IDX + 1) < fill);
  assign pair_left  = (IDX > 0) && (cmd.parity != PAR) && (CW'(IDX) < fill);

  always_comb begin
    word_nxt = word_r;
    unique case (cmd.act)
      ACT_LOAD_AT: begin
        if (sel_a == AW'(IDX)) word_nxt = val;
      end
      ACT_SHIFT_UP: begin
        word_nxt = (IDX == 0) ? val : left;
      end
      ACT_SHIFT_DN: begin
        if (IDX < CAPACITY - 1) word_nxt = right;
      end
      ACT_SWAP: begin
        if (sel_a == AW'(IDX)) word_nxt = dat_b;
        else if (sel_b == AW'(IDX)) word_nxt = dat_a;
      end
      ACT_SORT: begin
        if (pair_right && ($signed(right) < $signed(word_r))) word_nxt = right;
        else if (pair_left && ($signed(left) > $signed(word_r))) word_nxt = left;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

FILE: rtl/bdq_rdsel.sv
// Two-stage registered select tree that reads one cell of the row by address.
module bdq_rdsel import bdq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int AW      = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic [WORD_W-1:0] words [CAPACITY],
  input  logic [AW-1:0]     addr,
  output logic [WORD_W-1:0] data
);

  localparam int GRP = 32;
  localparam int NG  = (CAPACITY + GRP - 1) / GRP;

  logic [WORD_W-1:0] grp_r [NG];
  logic [WORD_W-1:0] grp_nxt [NG];
  logic [WORD_W-1:0] data_r, data_nxt;

  always_comb begin
    int n;
    n = 0;
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        n = g * GRP + k;
        if (n < CAPACITY) begin
          if (addr == AW'(n)) grp_nxt[g] = grp_nxt[g] | words[n];
        end
      end
    end
  end

  always_comb begin
    data_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      data_nxt = data_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_r  <= grp_nxt;
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

FILE: rtl/bdq_chk.sv
// Port-level checks on result items of the deque, bound to the top level.
module bdq_chk import bdq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_popped,
  input logic [CNT_W-1:0]  out_count,
  input logic [ST_W-1:0]   out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_popped) &&
                                $stable(out_count) && $stable(out_status))
    else $error("result item changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_count == CNT_W'(CAPACITY))
    else $error("dropped push reported with store not full");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_count == '0) && (out_popped == '0))
    else $error("empty pop with nonzero count or word");

  a_popped_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_popped != '0) |-> out_status == ST_OK)
    else $error("popped word on a failed item");

endmodule

bind bounded_deque_with_sort bdq_chk #(.CAPACITY(CAPACITY)) u_bdq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_popped (out_ch.popped),
  .out_count  (out_ch.count),
  .out_status (out_ch.status)
);

FILE: bench/tb.sv
// Self-checking bench for bounded_deque_with_sort: directed corners and random traffic against a mirror model.
`timescale 1ns / 100ps

module tb import bdq_pkg::*; ();

  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam int RANDOM_ITEMS = 1030;
  localparam int CALM_ITEMS   = 150;   // tail of the run with no idling
  localparam int SQUEEZE_AT   = 300;   // item index where the receiver holds off
  localparam int SQUEEZE_LEN  = 400;
  localparam int DRAIN_CYCLES = CAPACITY_DEF + 10;

  typedef struct {
    logic signed [WORD_W-1:0] popped;
    logic [CNT_W-1:0]         count;
    logic [ST_W-1:0]          status;
  } deque_result_t;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} traffic_phase_t;

  // Mirror of the deque contents; holds the results still owed by the block.
  class deque_mirror;
    logic signed [WORD_W-1:0] cells [CAPACITY_DEF];
    int fill;
    int errors;
    deque_result_t owed [$];

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void apply_request(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] val,
                                logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib);
      deque_result_t r;
      logic signed [WORD_W-1:0] t;
      int j;
      r.popped = '0;
      r.status = ST_OK;
      case (op)
        OP_PUSH_BACK: begin
          if (fill >= CAPACITY_DEF) r.status = ST_FULL;
          else begin
            cells[fill] = val;
            fill++;
          end
        end
        OP_POP_BACK: begin
          if (fill == 0) r.status = ST_EMPTY;
          else begin
            fill--;
            r.popped = cells[fill];
          end
        end
        OP_PUSH_FRONT: begin
          if (fill >= CAPACITY_DEF) r.status = ST_FULL;
          else begin
            for (j = fill; j > 0; j--) cells[j] = cells[j-1];
            cells[0] = val;
            fill++;
          end
        end
        OP_POP_FRONT: begin
          if (fill == 0) r.status = ST_EMPTY;
          else begin
            r.popped = cells[0];
            for (j = 0; j + 1 < fill; j++) cells[j] = cells[j+1];
            fill--;
          end
        end
        OP_SWAP: begin
          if (ia >= fill || ib >= fill) r.status = ST_RANGE;
          else begin
            t = cells[ia];
            cells[ia] = cells[ib];
            cells[ib] = t;
          end
        end
        OP_SORT: begin
          for (int i = 1; i < fill; i++) begin
            j = i;
            while (j > 0 && cells[j-1] > cells[j]) begin
              t = cells[j];
              cells[j] = cells[j-1];
              cells[j-1] = t;
              j--;
            end
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(fill);
      owed.push_back(r);
    endfunction

    function void check_result(deque_result_t got);
      deque_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result popped=%0d count=%0d status=%0d",
                 $time, got.popped, got.count, got.status);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.popped !== want.popped) begin
        $display("%0t: popped expected %0d actual %0d", $time, want.popped, got.popped);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  bounded_deque_with_sort uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deque_mirror mirror = new();
  bit calm;
  bit squeeze_req;
  int sent;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.value = '0;
    in_ch.index_a = '0;
    in_ch.index_b = '0;
    out_ch.ready = 1'b0;
  end

  // Offer one request item; returns at the falling edge after it is accepted.
  task automatic send_request(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] val,
                              logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.value <= val;
    in_ch.index_a <= ia;
    in_ch.index_b <= ib;
    do @(posedge clk); while (!in_ch.ready);
    mirror.apply_request(op, val, ia, ib);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      4, 5, 6: return $signed($urandom_range(0, 15)) - 8;  // duplicates for the sort
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if (mirror.fill > 0 && $urandom_range(0, 99) < 80)
      return IDX_W'($urandom_range(0, mirror.fill - 1));
    return IDX_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [OP_W-1:0] pick_op(traffic_phase_t ph);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OP_SORT;
    if (roll < 5) return ($urandom_range(0, 1) != 0) ? OP_UNUSED_6 : OP_UNUSED_7;
    if (roll < 15) return OP_SWAP;
    case (ph)
      PH_GROW:   roll = ($urandom_range(0, 99) < 85) ? 0 : 1;
      PH_SHRINK: roll = ($urandom_range(0, 99) < 85) ? 1 : 0;
      default:   roll = $urandom_range(0, 1);
    endcase
    if (roll == 0) return ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    return ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  // Receiver: random back-pressure bursts, one long hold-off on request.
  initial begin
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (squeeze_req) begin
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_LEN) @(negedge clk);
        squeeze_req = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    deque_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.popped = out_ch.popped;
      got.count = out_ch.count;
      got.status = out_ch.status;
      mirror.check_result(got);
    end
  end

  initial begin
    traffic_phase_t ph;
    int left_in_phase;
    logic [OP_W-1:0] op;
    calm = 1'b0;
    squeeze_req = 1'b0;
    sent = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-store errors, unused codes, extremes, swap and sort corners
    send_request(OP_POP_BACK, '0, '0, '0);
    send_request(OP_POP_FRONT, '0, '0, '0);
    send_request(OP_SWAP, '0, 6'd0, 6'd0);
    send_request(OP_SORT, '0, '0, '0);
    send_request(OP_UNUSED_6, -32'sd1, 6'd63, 6'd63);
    send_request(OP_UNUSED_7, -32'sd1, 6'd63, 6'd63);
    send_request(OP_PUSH_BACK, 32'sh7fffffff, '0, '0);
    send_request(OP_SORT, '0, '0, '0);
    send_request(OP_PUSH_BACK, 32'sh80000000, '0, '0);
    send_request(OP_PUSH_FRONT, '0, '0, '0);
    send_request(OP_PUSH_FRONT, -32'sd1, '0, '0);
    send_request(OP_SWAP, '0, 6'd0, 6'd0);
    send_request(OP_SWAP, '0, 6'd3, 6'd63);
    send_request(OP_SWAP, '0, 6'd63, 6'd0);
    send_request(OP_SWAP, '0, 6'd4, 6'd1);
    send_request(OP_SWAP, '0, 6'd0, 6'd3);
    send_request(OP_SORT, '0, '0, '0);
    send_request(OP_UNUSED_6, 32'sh55555555, 6'd0, 6'd1);
    send_request(OP_POP_FRONT, '0, '0, '0);
    send_request(OP_POP_BACK, '0, '0, '0);
    send_request(OP_POP_BACK, '0, '0, '0);
    send_request(OP_POP_FRONT, '0, '0, '0);
    send_request(OP_POP_FRONT, '0, '0, '0);

    ph = PH_GROW;
    left_in_phase = 80;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (left_in_phase == 0) begin
        // grow and shrink dominate so the store often hits full and empty
        case ($urandom_range(0, 4))
          0, 1: ph = PH_GROW;
          2, 3: ph = PH_SHRINK;
          default: ph = PH_MIX;
        endcase
        left_in_phase = $urandom_range(20, 100);
      end
      left_in_phase--;
      if (n == SQUEEZE_AT) squeeze_req = 1'b1;
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      op = pick_op(ph);
      send_request(op, pick_value(), pick_index(), pick_index());
    end
    in_ch.valid <= 1'b0;

    while (mirror.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_cell.sv
rtl/bdq_rdsel.sv
rtl/bounded_deque_with_sort.sv
rtl/bdq_chk.sv
bench/tb.sv
